### design/c32s16_pkg.sv
// Shared types, constants and elaboration-time CRC-32 matrices for the slice-by-16 engine.
// Depends on nothing; every other file in the design folder imports it.
`default_nettype none

package c32s16_pkg;

  localparam int unsigned BYTES    = 16;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned CRC_W    = 32;
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_MASK = 32'hFFFFFFFF;
  localparam int unsigned IN_DW    = 168;

  typedef logic [CRC_W-1:0] col32_t;
  typedef col32_t [7:0] byte_cols_t;
  typedef byte_cols_t [BYTES-1:0] lane_cols_t;
  typedef col32_t [CRC_W-1:0] word_cols_t;
  typedef word_cols_t [BYTES:0] zero_cols_t;

  typedef struct packed {
    logic             valid;
    logic             start;
    logic [CRC_W-1:0] init;
    logic [CNT_W-1:0] nbytes;
    logic [CRC_W-1:0] dpart;
  } stage_t;

  function automatic logic [CRC_W-1:0] shift_bits(logic [CRC_W-1:0] r, int unsigned nbits);
    logic [CRC_W-1:0] v;
    v = r;
    for (int unsigned s = 0; s < nbits; s++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

  // Column b of lane table j: a single bit b of a data byte followed by j zero bytes.
  function automatic lane_cols_t gen_lane_cols();
    lane_cols_t t;
    for (int unsigned j = 0; j < BYTES; j++) begin
      for (int unsigned b = 0; b < 8; b++) begin
        t[j][b] = shift_bits(col32_t'(1) << b, 8 * (j + 1));
      end
    end
    return t;
  endfunction

  // Column i of matrix n: state bit i advanced over n zero bytes.
  function automatic zero_cols_t gen_zero_cols();
    zero_cols_t t;
    for (int unsigned n = 0; n <= BYTES; n++) begin
      for (int unsigned i = 0; i < CRC_W; i++) begin
        t[n][i] = shift_bits(col32_t'(1) << i, 8 * n);
      end
    end
    return t;
  endfunction

  localparam lane_cols_t LANE_COLS = gen_lane_cols();
  localparam zero_cols_t ZERO_COLS = gen_zero_cols();

endpackage

`default_nettype wire

### design/c32s16_lane.sv
// One byte lane: multiplies a data byte by its fixed 8x32 CRC column matrix.
// Depends on c32s16_pkg for the column type.
`default_nettype none

module c32s16_lane (
  input  wire logic [7:0]              lane_byte,
  input  wire c32s16_pkg::byte_cols_t  cols,
  output logic [c32s16_pkg::CRC_W-1:0] part
);
  import c32s16_pkg::*;

  always_comb begin
    part = '0;
    for (int unsigned b = 0; b < 8; b++) begin
      if (lane_byte[b]) begin
        part = part ^ cols[b];
      end
    end
  end

endmodule

`default_nettype wire

### design/c32s16_front.sv
// Input stage: moves the valid bytes to the top lanes, runs sixteen lanes and merges their parts.
// Depends on c32s16_pkg and c32s16_lane.
`default_nettype none

module c32s16_front (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [c32s16_pkg::IN_DW-1:0] in_tdata,
  input  wire logic                     in_tuser,
  input  wire logic                     down_ready,
  output c32s16_pkg::stage_t            stage
);
  import c32s16_pkg::*;

  logic                     valid_r;
  logic                     valid_nxt;
  logic                     start_r;
  logic [CRC_W-1:0]         init_r;
  logic [CNT_W-1:0]         nbytes_r;
  logic [CRC_W-1:0]         dpart_r;
  logic [CNT_W-1:0]         cnt;
  logic [CNT_W-1:0]         nbytes;
  logic [CNT_W-1:0]         lead;
  logic [8*BYTES-1:0]       chunk;
  logic [8*BYTES-1:0]       aligned;
  logic [CRC_W-1:0]         parts [BYTES];
  logic [CRC_W-1:0]         dpart;
  logic                     advance;
  logic                     take;

  assign cnt     = in_tdata[164:160];
  assign nbytes  = (cnt > CNT_W'(BYTES)) ? CNT_W'(BYTES) : cnt;
  assign lead    = CNT_W'(BYTES) - nbytes;
  assign chunk   = {in_tdata[159:96], in_tdata[95:32]};
  assign aligned = chunk << {lead, 3'b000};

  // Leading zero bytes from a zero state contribute nothing, so only the
  // valid bytes, moved to the top lanes, shape the data part.
  for (genvar j = 0; j < BYTES; j++) begin : g_lane
    c32s16_lane u_lane (
      .lane_byte (aligned[8*j +: 8]),
      .cols      (LANE_COLS[BYTES-1-j]),
      .part      (parts[j])
    );
  end

  always_comb begin
    dpart = '0;
    for (int unsigned j = 0; j < BYTES; j++) begin
      dpart = dpart ^ parts[j];
    end
  end

  assign advance   = !valid_r || down_ready;
  assign in_tready = advance;
  assign take      = in_tvalid && advance;
  assign valid_nxt = advance ? in_tvalid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      start_r  <= in_tuser;
      init_r   <= in_tdata[31:0];
      nbytes_r <= nbytes;
      dpart_r  <= dpart;
    end
  end

  assign stage = '{valid: valid_r, start: start_r, init: init_r,
                   nbytes: nbytes_r, dpart: dpart_r};

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> nbytes_r <= CNT_W'(BYTES))
    else $error("Registered byte count exceeds the chunk size.");

  a_empty_part: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && nbytes_r == '0) |-> dpart_r == '0)
    else $error("An empty item produced a nonzero data part.");

endmodule

`default_nettype wire

### design/c32s16_merge.sv
// Merge stage: advances the running CRC over the item's byte count and adds the data part.
// Depends on c32s16_pkg for the stage struct and the zero-byte matrices.
`default_nettype none

module c32s16_merge (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire c32s16_pkg::stage_t       stage,
  output logic                          down_ready,
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  output logic [c32s16_pkg::CRC_W-1:0]  out_tdata
);
  import c32s16_pkg::*;

  logic             ovalid_r;
  logic             ovalid_nxt;
  logic [CRC_W-1:0] running_r;
  logic [CRC_W-1:0] running_nxt;
  logic [CRC_W-1:0] crc_r;
  logic [CRC_W-1:0] base;
  logic [CRC_W-1:0] folded;
  logic             advance;
  logic             load;
  word_cols_t       zcols;

  assign advance    = !ovalid_r || out_tready;
  assign down_ready = advance;
  assign load       = stage.valid && advance;
  assign ovalid_nxt = advance ? stage.valid : ovalid_r;

  assign base  = stage.start ? ~stage.init : running_r;
  assign zcols = ZERO_COLS[stage.nbytes];

  always_comb begin
    folded = '0;
    for (int unsigned i = 0; i < CRC_W; i++) begin
      if (base[i]) begin
        folded = folded ^ zcols[i];
      end
    end
    running_nxt = folded ^ stage.dpart;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r  <= 1'b0;
      running_r <= CRC_MASK;
    end else begin
      ovalid_r <= ovalid_nxt;
      if (load) begin
        running_r <= running_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      crc_r <= ~running_nxt;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = crc_r;

  a_reset_value: assert property (@(posedge clk)
    !rst_n |=> running_r == CRC_MASK)
    else $error("Running CRC not at all ones after reset.");

  a_out_matches: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> crc_r == ~running_r)
    else $error("Presented CRC does not match the running value.");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovalid_r) |-> $past(stage.valid))
    else $error("Result appeared without a staged item.");

endmodule

`default_nettype wire

### design/crc32_slice16_engine_core.sv
// Top level of the CRC-32 slice-by-16 engine: front lane stage feeding the merge stage.
// Depends on c32s16_pkg, c32s16_front and c32s16_merge.
//
//  Channel | Direction | Handshake          | Payload
//  in_     | input     | in_tvalid/tready   | tdata: seed, 16 data bytes, count; tuser: start
//  out_    | output    | out_tvalid/tready  | tdata: finished CRC
//
// Front and merge stages each register an item; one item per cycle while out_tready is high.
// The running CRC register in the merge stage closes a feedback loop over the item count.
// Synchronous reset sets the running CRC to all ones and empties both stages.
// A stalled output holds its result; the front stage keeps accepting until it is full.
`default_nettype none

module crc32_slice16_engine_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // Fields from bit 0: init_value[31:0], data_low[95:32], data_high[159:96],
  // byte_count[164:160], zero fill[167:165].
  input  wire logic [c32s16_pkg::IN_DW-1:0]  in_tdata,
  // Fields from bit 0: start_req[0].
  input  wire logic                          in_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // Fields from bit 0: crc[31:0].
  output logic [c32s16_pkg::CRC_W-1:0]       out_tdata
);
  import c32s16_pkg::*;

  stage_t stage;
  logic   down_ready;

  c32s16_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .down_ready (down_ready),
    .stage      (stage)
  );

  c32s16_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .stage      (stage),
    .down_ready (down_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
